@@ rtl/dag_ready_queue_scheduler_top_macros.svh @@
// Assertion macros used by the checker file
`ifndef DAG_READY_QUEUE_SCHEDULER_TOP_MACROS_SVH
`define DAG_READY_QUEUE_SCHEDULER_TOP_MACROS_SVH
// implication checked every clock outside reset
`define DRQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked every clock outside reset
`define DRQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/drq_pkg.sv @@
// Package: widths, action codes, status codes and word types
`default_nettype none
package drq_pkg;
  localparam int NumNodes    = 16;
  localparam int MaxChildren = 8;
  localparam int NodeW  = 4;
  localparam int ChildW = 3;
  localparam int CntW   = 4;
  localparam int QLenW  = 5;
  localparam int KeyW   = 16;

  typedef enum logic [2:0] {
    ACT_INIT = 3'd0, ACT_PRIO = 3'd1, ACT_WEIGHT = 3'd2, ACT_ADD_DEP = 3'd3,
    ACT_SUBMIT = 3'd4, ACT_POP = 3'd5, ACT_COMPLETE = 3'd6, ACT_NOP = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_CHILD_FULL = 2'd1, ST_QUEUE_FULL = 2'd2, ST_RSVD = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [NodeW-1:0] node_id;
    logic [NodeW-1:0] child_id;
    logic signed [7:0] prio_value;
    logic signed [7:0] weight_value;
  } in_word_t;

  typedef struct packed {
    logic             popped_valid;
    logic [NodeW-1:0] popped_node;
    logic [1:0]       status;
    logic [QLenW-1:0] ready_count;
  } out_word_t;
endpackage
`default_nettype wire

@@ rtl/drq_if.sv @@
// Valid/ready channel interfaces for input and result words
`default_nettype none
interface drq_in_if;
  import drq_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface drq_out_if;
  import drq_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/dag_ready_queue_scheduler_top.sv @@
// Top level: dependency-counting priority ready queue for a 16-node task graph
//
// One input word is taken at a time and answered by exactly one result word.
// Node attributes (priority, weight, pending count, child count) sit in one
// synchronous node memory, child lists in a 128-entry child memory, and the
// ready queue (node, key) in a 16-entry queue memory, each read through a
// registered output. Init, set priority, set weight, pop on an empty queue,
// the unused action, a full child list, a submit of a node still pending and
// a complete with no children go from the execute step straight to the
// result; add dependency updates the parent, then reads the child and
// increments its pending count with saturation. A sorted insert walks the
// queue from its tail, reading each entry looked at, then comparing it and
// shifting it down; pop shifts the queue up entry by entry. Complete reads
// each child in turn and updates its pending count, plus one insert for
// every child that becomes ready. The result register parts the two sides:
// the next word is taken while a result still waits, and the block holds in
// its last step until that result is taken.
// No clearing pass is needed: node state resets through per-node valid bits.
`default_nettype none
module dag_ready_queue_scheduler_top (
  input  wire logic clk,
  input  wire logic rst_n,
  drq_in_if.sink    in_ch,
  drq_out_if.source out_ch
);
  import drq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DEP_RD, S_DEP_UPD, S_CH_RD, S_CH_NODE, S_CH_EXEC,
    S_INS_RD, S_INS_CMP, S_POP_RD, S_POP_MV, S_DONE
  } state_t;

  typedef struct packed {
    logic signed [7:0] prio;
    logic [7:0]        weight;
    logic [7:0]        pending;
    logic [CntW-1:0]   ccount;
  } node_t;

  // node memory with per-entry valid bits standing in for reset values
  node_t             node_mem [NumNodes];
  logic [NumNodes-1:0] node_vld_r;
  logic [NodeW-1:0]  child_mem [NumNodes*MaxChildren];
  logic [NodeW-1:0]  qn_mem [NumNodes];
  logic [KeyW-1:0]   qk_mem [NumNodes];

  state_t            state_r;
  in_word_t          w_r;
  node_t             nrd_raw_r;
  logic              nrd_vld_r;
  node_t             nrd;
  logic [NodeW-1:0]  crd_r;
  logic [NodeW-1:0]  qn_rd_r;
  logic [KeyW-1:0]   qk_rd_r;
  logic [QLenW-1:0]  qlen_r;
  logic [QLenW-1:0]  pos_r;
  logic [CntW-1:0]   k_r;
  logic [NodeW-1:0]  cur_r;
  logic signed [KeyW-1:0] key_r;
  logic [1:0]        status_r;
  logic              pop_vld_r;
  logic [NodeW-1:0]  pop_node_r;
  out_word_t         out_r;
  logic              out_vld_r;

  // node memory ports
  logic              n_we;
  logic [NodeW-1:0]  n_waddr;
  node_t             n_wdata;
  logic [NodeW-1:0]  n_raddr;
  // queue memory ports
  logic              q_we;
  logic [NodeW-1:0]  q_waddr;
  logic [NodeW-1:0]  q_wnode;
  logic [KeyW-1:0]   q_wkey;
  logic [NodeW-1:0]  q_raddr;
  // child memory ports
  logic              c_we;
  logic [ChildW+NodeW-1:0] c_waddr;
  logic [ChildW+NodeW-1:0] c_raddr;

  // sort key of the node just read: priority times weight
  logic signed [KeyW-1:0] prio_ext;
  logic signed [KeyW-1:0] wt_ext;
  logic signed [KeyW-1:0] key_calc;
  logic [QLenW-1:0]  pos_m1;
  logic [CntW-1:0]   k_m1;
  logic              out_free;

  assign nrd = nrd_vld_r ? nrd_raw_r :
               '{prio: 8'sd0, weight: 8'd1, pending: 8'd0, ccount: '0};

  assign prio_ext = {{(KeyW-8){nrd.prio[7]}}, nrd.prio};
  assign wt_ext   = {{(KeyW-8){1'b0}}, nrd.weight};
  assign key_calc = prio_ext * wt_ext;
  assign pos_m1   = pos_r - QLenW'(1);
  assign k_m1     = k_r - CntW'(1);
  // result register empty or emptied at this edge
  assign out_free = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (n_we) node_mem[n_waddr] <= n_wdata;
    nrd_raw_r <= node_mem[n_raddr];
    if (q_we) begin
      qn_mem[q_waddr] <= q_wnode;
      qk_mem[q_waddr] <= q_wkey;
    end
    qn_rd_r <= qn_mem[q_raddr];
    qk_rd_r <= qk_mem[q_raddr];
    if (c_we) child_mem[c_waddr] <= w_r.child_id;
    crd_r <= child_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_vld_r <= '0;
      nrd_vld_r  <= 1'b0;
    end else begin
      if (n_we) node_vld_r[n_waddr] <= 1'b1;
      nrd_vld_r <= node_vld_r[n_raddr];
    end
  end

  // Memory addressing. Every read of an entry is issued after the edge that
  // holds its last write, so no forwarding is needed.
  always_comb begin
    n_we = 1'b0; n_waddr = w_r.node_id; n_wdata = nrd; n_raddr = w_r.node_id;
    q_we = 1'b0; q_waddr = pos_r[NodeW-1:0]; q_wnode = qn_rd_r; q_wkey = qk_rd_r;
    q_raddr = pos_r[NodeW-1:0];
    c_we = 1'b0;
    c_waddr = {w_r.node_id, nrd.ccount[ChildW-1:0]};
    c_raddr = {w_r.node_id, k_m1[ChildW-1:0]};
    case (state_r)
      S_IDLE: n_raddr = in_ch.data.node_id;
      S_EXEC: begin
        case (action_t'(w_r.action))
          ACT_INIT: begin
            n_we = 1'b1;
            n_wdata = '{prio: 8'sd0, weight: 8'd1, pending: 8'd0, ccount: '0};
          end
          ACT_PRIO: begin
            n_we = 1'b1; n_wdata.prio = w_r.prio_value;
          end
          ACT_WEIGHT: begin
            n_we = 1'b1;
            n_wdata.weight = (w_r.weight_value > 8'sd0) ? $unsigned(w_r.weight_value)
                                                       : 8'd1;
          end
          ACT_ADD_DEP: begin
            // append the child and bump the parent's child count
            if (nrd.ccount < CntW'(MaxChildren)) begin
              n_we = 1'b1; n_wdata.ccount = nrd.ccount + CntW'(1);
              c_we = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_DEP_RD:  n_raddr = w_r.child_id;
      S_DEP_UPD: begin
        // saturating increment of the child's pending count
        n_waddr = w_r.child_id;
        if (nrd.pending != 8'hFF) begin
          n_we = 1'b1; n_wdata.pending = nrd.pending + 8'd1;
        end
      end
      S_CH_NODE: n_raddr = crd_r;
      S_CH_EXEC: begin
        n_waddr = cur_r;
        if (nrd.pending != 8'd0) begin
          n_we = 1'b1; n_wdata.pending = nrd.pending - 8'd1;
        end
      end
      S_INS_RD:  q_raddr = pos_m1[NodeW-1:0];
      S_INS_CMP: begin
        // place the new entry here or shift the one above down
        q_we = 1'b1;
        if (pos_r == '0 || $signed(qk_rd_r) >= key_r) begin
          q_wnode = cur_r; q_wkey = key_r;
        end
      end
      S_POP_MV: begin
        // move the entry just read up by one; the head is only captured
        q_waddr = pos_m1[NodeW-1:0];
        q_we = (pos_r != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; qlen_r <= '0; out_vld_r <= 1'b0;
    end else begin
      // load the result register, or drop the word taken downstream
      if (state_r == S_DONE && out_free) begin
        out_vld_r <= 1'b1;
        out_r <= '{popped_valid: pop_vld_r, popped_node: pop_node_r,
                   status: status_r, ready_count: qlen_r};
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            w_r <= in_ch.data; status_r <= ST_OK;
            pop_vld_r <= 1'b0; pop_node_r <= '0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (action_t'(w_r.action))
            ACT_ADD_DEP: begin
              if (nrd.ccount >= CntW'(MaxChildren)) begin
                status_r <= ST_CHILD_FULL; state_r <= S_DONE;
              end else begin
                state_r <= S_DEP_RD;
              end
            end
            ACT_SUBMIT: begin
              cur_r <= w_r.node_id; key_r <= key_calc; pos_r <= qlen_r;
              if (nrd.pending != 8'd0) begin
                state_r <= S_DONE;
              end else if (qlen_r >= QLenW'(NumNodes)) begin
                status_r <= ST_QUEUE_FULL; state_r <= S_DONE;
              end else begin
                state_r <= S_INS_RD;
              end
            end
            ACT_POP: begin
              pos_r <= '0;
              state_r <= (qlen_r != '0) ? S_POP_RD : S_DONE;
            end
            ACT_COMPLETE: begin
              // walk the children newest first
              k_r <= nrd.ccount;
              state_r <= (nrd.ccount != '0) ? S_CH_RD : S_DONE;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_DEP_RD:  state_r <= S_DEP_UPD;
        S_DEP_UPD: state_r <= S_DONE;
        S_CH_RD:   state_r <= S_CH_NODE;
        S_CH_NODE: begin
          cur_r <= crd_r;
          state_r <= S_CH_EXEC;
        end
        S_CH_EXEC: begin
          k_r <= k_m1;
          key_r <= key_calc;
          pos_r <= qlen_r;
          if (nrd.pending == 8'd1 && qlen_r < QLenW'(NumNodes)) begin
            state_r <= S_INS_RD;
          end else begin
            // a full queue drops this child and the walk goes on
            if (nrd.pending == 8'd1) status_r <= ST_QUEUE_FULL;
            state_r <= (k_m1 != '0) ? S_CH_RD : S_DONE;
          end
        end
        S_INS_RD: state_r <= S_INS_CMP;
        S_INS_CMP: begin
          if (pos_r == '0 || $signed(qk_rd_r) >= key_r) begin
            qlen_r <= qlen_r + QLenW'(1);
            state_r <= (action_t'(w_r.action) == ACT_COMPLETE && k_r != '0) ?
                       S_CH_RD : S_DONE;
          end else begin
            pos_r <= pos_m1;
            state_r <= S_INS_RD;
          end
        end
        S_POP_RD: state_r <= S_POP_MV;
        S_POP_MV: begin
          if (pos_r == '0) begin
            pop_vld_r <= 1'b1; pop_node_r <= qn_rd_r;
          end
          if (pos_r + QLenW'(1) >= qlen_r) begin
            qlen_r <= qlen_r - QLenW'(1); state_r <= S_DONE;
          end else begin
            pos_r <= pos_r + QLenW'(1); state_r <= S_POP_RD;
          end
        end
        S_DONE: begin
          // hold until the previous result word has left
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_vld_r;
  assign out_ch.data = out_r;
endmodule
`default_nettype wire

@@ rtl/drq_checker.sv @@
// Port-level checker for the ready queue scheduler, bound to the top level
`include "dag_ready_queue_scheduler_top_macros.svh"
`default_nettype none
module drq_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_popped_valid,
  input wire logic [3:0] out_popped_node,
  input wire logic [1:0] out_status,
  input wire logic [4:0] out_ready_count
);
  `DRQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `DRQ_ASSERT_IMP(a_count_rng, out_valid, out_ready_count <= 5'd16, "ready count out of range")
  `DRQ_ASSERT_IMP(a_no_pop_node, out_valid && !out_popped_valid, out_popped_node == 4'd0, "node without pop")
  `DRQ_ASSERT_NXT(a_one_word, in_valid && in_ready, !in_ready, "second word taken early")
endmodule

bind dag_ready_queue_scheduler_top drq_checker u_drq_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_popped_valid(out_ch.data.popped_valid),
  .out_popped_node(out_ch.data.popped_node),
  .out_status(out_ch.data.status),
  .out_ready_count(out_ch.data.ready_count)
);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench top: drives scheduler actions, predicts each result word and checks it
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import drq_pkg::*;

  logic clk;
  logic rst_n;

  drq_in_if  in_ch ();
  drq_out_if out_ch ();

  dag_ready_queue_scheduler_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow state: node table, child lists and the sorted ready queue.
  // ---------------------------------------------------------------------------
  logic signed [7:0] sh_prio   [NumNodes];
  logic [7:0]        sh_weight [NumNodes];
  logic [7:0]        sh_pending[NumNodes];
  int                sh_nchild [NumNodes];
  logic [NodeW-1:0]  sh_child  [NumNodes][MaxChildren];
  logic [NodeW-1:0]  rq_node   [NumNodes];
  int                rq_key    [NumNodes];
  int                rq_len;

  out_word_t expected_words[$];
  int        error_count;
  int        words_sent;

  function automatic void clear_shadow();
    for (int i = 0; i < NumNodes; i++) begin
      sh_prio[i]    = '0;
      sh_weight[i]  = 8'd1;
      sh_pending[i] = '0;
      sh_nchild[i]  = 0;
    end
    rq_len = 0;
  endfunction

  // Sorted insert by descending key; equal keys land behind the existing ones.
  // Return 0 when the queue has no room.
  function automatic bit rq_insert(logic [NodeW-1:0] id);
    int key;
    int pos;
    key = int'(sh_prio[id]) * int'(sh_weight[id]);
    if (rq_len >= NumNodes) return 1'b0;
    pos = 0;
    while (pos < rq_len && rq_key[pos] >= key) pos++;
    for (int i = rq_len; i > pos; i--) begin
      rq_node[i] = rq_node[i-1];
      rq_key[i]  = rq_key[i-1];
    end
    rq_node[pos] = id;
    rq_key[pos]  = key;
    rq_len++;
    return 1'b1;
  endfunction

  function automatic out_word_t schedule_action(in_word_t w);
    out_word_t r;
    logic [NodeW-1:0] c;
    r = '0;
    r.status = ST_OK;
    case (action_t'(w.action))
      ACT_INIT: begin
        sh_prio[w.node_id]    = '0;
        sh_weight[w.node_id]  = 8'd1;
        sh_pending[w.node_id] = '0;
        sh_nchild[w.node_id]  = 0;
      end
      ACT_PRIO:   sh_prio[w.node_id] = w.prio_value;
      ACT_WEIGHT: sh_weight[w.node_id] = (w.weight_value > 0) ? w.weight_value : 8'd1;
      ACT_ADD_DEP: begin
        if (sh_nchild[w.node_id] >= MaxChildren) begin
          r.status = ST_CHILD_FULL;
        end else begin
          sh_child[w.node_id][sh_nchild[w.node_id]] = w.child_id;
          sh_nchild[w.node_id]++;
          if (sh_pending[w.child_id] != 8'hFF) sh_pending[w.child_id]++;
        end
      end
      ACT_SUBMIT: begin
        if (sh_pending[w.node_id] == 0 && !rq_insert(w.node_id)) r.status = ST_QUEUE_FULL;
      end
      ACT_COMPLETE: begin
        // Walk children newest first; keep going after a dropped enqueue.
        for (int k = sh_nchild[w.node_id]; k > 0; k--) begin
          c = sh_child[w.node_id][k-1];
          if (sh_pending[c] != 0) begin
            sh_pending[c]--;
            if (sh_pending[c] == 0 && !rq_insert(c)) r.status = ST_QUEUE_FULL;
          end
        end
      end
      ACT_POP: begin
        if (rq_len > 0) begin
          r.popped_valid = 1'b1;
          r.popped_node  = rq_node[0];
          for (int k = 1; k < rq_len; k++) begin
            rq_node[k-1] = rq_node[k];
            rq_key[k-1]  = rq_key[k];
          end
          rq_len--;
        end
      end
      default: ;
    endcase
    r.ready_count = rq_len[QLenW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check the result word first, then predict any word accepted on
  // the same edge, so that the expectation order follows the block.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result word", 1, 0);
        end else begin
          want = expected_words.pop_front();
          if (got.popped_valid !== want.popped_valid)
            report_mismatch("popped_valid", got.popped_valid, want.popped_valid);
          if (got.popped_node !== want.popped_node)
            report_mismatch("popped_node", got.popped_node, want.popped_node);
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.ready_count !== want.ready_count)
            report_mismatch("ready_count", got.ready_count, want.ready_count);
        end
      end
      if (in_ch.valid && in_ch.ready) expected_words.push_back(schedule_action(in_ch.data));
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, plus one long hold-off on request so the
  // block backs up and stalls its input while the driver keeps offering.
  // ---------------------------------------------------------------------------
  int  hold_left;
  bit  long_hold_req;
  int  stall_left;

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Stretches with no new stalls when this is set.
  bit calm_phase;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      stall_left   <= 0;
    end else if (long_hold_req && hold_left == 0) begin
      long_hold_req = 1'b0;
      hold_left    <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm_phase && $urandom_range(3) == 0) stall_left <= pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  bit calm_drive;

  task automatic send_word(action_t act, int node, int child = 0, int prio = 0, int wt = 0);
    in_word_t w;
    int gap;
    w.action       = act;
    w.node_id      = node[NodeW-1:0];
    w.child_id     = child[NodeW-1:0];
    w.prio_value   = prio[7:0];
    w.weight_value = wt[7:0];
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    // Hold valid high straight into the next word when there is no gap.
    gap = calm_drive ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    // let the monitor record the last accepted word first
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_setup_and_order();
    send_word(ACT_POP, 0);                          // pop on an empty queue
    send_word(ACT_NOP, 15, 15, -1, -1);              // unused action code
    send_word(ACT_PRIO, 1, 0, 127);
    send_word(ACT_WEIGHT, 1, 0, 0, 127);
    send_word(ACT_PRIO, 2, 0, -128);
    send_word(ACT_WEIGHT, 2, 0, 0, -128);            // negative weight clamps to one
    send_word(ACT_PRIO, 3, 0, 5);
    send_word(ACT_WEIGHT, 3, 0, 0, 0);               // zero weight clamps to one
    send_word(ACT_SUBMIT, 2);
    send_word(ACT_SUBMIT, 3);
    send_word(ACT_SUBMIT, 1);
    send_word(ACT_SUBMIT, 3);                        // duplicate entry, equal key
    send_word(ACT_INIT, 3);                          // queued entries stay put
    repeat (5) send_word(ACT_POP, 0);
    drain();
  endtask

  task automatic test_dependencies();
    send_word(ACT_INIT, 0);
    for (int i = 0; i < 9; i++) send_word(ACT_ADD_DEP, 0, 4 + (i % 3)); // ninth: list full
    send_word(ACT_SUBMIT, 4);                        // pending, nothing queued
    send_word(ACT_COMPLETE, 0);
    send_word(ACT_COMPLETE, 0);                      // list kept, but the counts are already zero
    send_word(ACT_COMPLETE, 0);                      // counts already zero
    send_word(ACT_COMPLETE, 15);                     // no children
    repeat (4) send_word(ACT_POP, 0);
    drain();
  endtask

  task automatic test_queue_full();
    for (int i = 0; i < 18; i++) send_word(ACT_SUBMIT, i % NumNodes);
    send_word(ACT_INIT, 9);
    send_word(ACT_ADD_DEP, 9, 10);
    send_word(ACT_COMPLETE, 9);                      // enqueue from complete dropped
    repeat (17) send_word(ACT_POP, 0);
    drain();
  endtask

  task automatic test_pending_saturation();
    for (int i = 0; i < 264; i++) begin
      if (i % MaxChildren == 0) send_word(ACT_INIT, 11);
      send_word(ACT_ADD_DEP, 11, 12);
    end
    send_word(ACT_COMPLETE, 11);
    send_word(ACT_SUBMIT, 12);
    send_word(ACT_INIT, 12);
    drain();
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    calm_drive = 1'b1;
    for (int i = 0; i < 12; i++) send_word(ACT_SUBMIT, $urandom_range(15));
    for (int i = 0; i < 12; i++) send_word(ACT_POP, 0);
    calm_drive = 1'b0;
    drain();
  endtask

  task automatic send_random_noise();
    send_word(action_t'($urandom_range(7)), $urandom_range(15), $urandom_range(15),
              $urandom_range(255), $urandom_range(255));
  endtask

  // A small task graph: set up nodes, link parents to children, submit every
  // node (those still pending stay out), then retire work by popping and completing.
  task automatic send_random_graph();
    int n;
    int base;
    n = $urandom_range(6, 2);
    base = $urandom_range(15);
    for (int i = 0; i < n; i++) begin
      send_word(ACT_INIT, (base + i) % NumNodes);
      send_word(ACT_PRIO, (base + i) % NumNodes, 0, $urandom_range(255));
      if ($urandom_range(1)) send_word(ACT_WEIGHT, (base + i) % NumNodes, 0, 0,
                                       $urandom_range(255));
    end
    for (int i = 0; i < n; i++)
      send_word(ACT_ADD_DEP, (base + $urandom_range(n - 1)) % NumNodes,
                (base + $urandom_range(n - 1)) % NumNodes);
    for (int i = 0; i < n; i++) send_word(ACT_SUBMIT, (base + i) % NumNodes);
    for (int i = 0; i < n; i++) begin
      send_word(ACT_POP, 0);
      send_word(ACT_COMPLETE, (base + $urandom_range(n - 1)) % NumNodes);
    end
  endtask

  task automatic test_random_graphs();
    int start;
    start = words_sent;
    while (words_sent - start < 1250) begin
      calm_phase = ($urandom_range(7) == 0);
      if ($urandom_range(4) == 0) begin
        for (int i = 0; i < 8; i++) send_random_noise();
      end else begin
        send_random_graph();
      end
    end
    calm_phase = 1'b0;
    drain();
  endtask

  initial begin
    error_count   = 0;
    words_sent    = 0;
    long_hold_req = 1'b0;
    calm_phase    = 1'b0;
    calm_drive    = 1'b0;
    clear_shadow();
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_setup_and_order();
    test_dependencies();
    test_queue_full();
    test_pending_saturation();
    test_backpressure();
    test_random_graphs();

    if (expected_words.size() != 0) report_mismatch("result words missing", 0,
                                                    expected_words.size());
    if (error_count == 0) begin
      $display("PASS dag_ready_queue_scheduler_top");
    end else begin
      $display("FAIL dag_ready_queue_scheduler_top");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #50ms;
    $display("FAIL dag_ready_queue_scheduler_top");
    $finish;
  end
endmodule
`default_nettype wire
